// ----- src/flbt_pkg.sv -----
`default_nettype none
package flbt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int SHIFT_W = 5;
  localparam int COUNT_W = 5;
  localparam int WIN_W   = DELAY_W + (1 << COUNT_W) - 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FAIL    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUCCESS = 2'd2;

  localparam logic [DELAY_W-1:0] BASE_DELAY_RST = 16'd500;
  localparam logic [SHIFT_W-1:0] MAX_SHIFT_RST  = 5'd13;

  // register index taken from address bit 2
  localparam logic REG_BASE_DELAY = 1'b0;
  localparam logic REG_MAX_SHIFT  = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] ip_addr;
    logic [TIME_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic entry_dropped;
    logic banned;
  } result_t;

  typedef struct packed {
    logic [DELAY_W-1:0] base_delay;
    logic [SHIFT_W-1:0] max_shift;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/flbt_cfg.sv -----
`default_nettype none
module flbt_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output flbt_pkg::cfg_t   cfg
);

  logic [flbt_pkg::DELAY_W-1:0] base_delay_r;
  logic [flbt_pkg::SHIFT_W-1:0] max_shift_r;
  logic                         wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r <= flbt_pkg::BASE_DELAY_RST;
      max_shift_r  <= flbt_pkg::MAX_SHIFT_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        flbt_pkg::REG_BASE_DELAY: base_delay_r <= cfg_pwdata[flbt_pkg::DELAY_W-1:0];
        flbt_pkg::REG_MAX_SHIFT:  max_shift_r  <= cfg_pwdata[flbt_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      flbt_pkg::REG_BASE_DELAY: cfg_prdata = {{(32-flbt_pkg::DELAY_W){1'b0}}, base_delay_r};
      flbt_pkg::REG_MAX_SHIFT:  cfg_prdata = {{(32-flbt_pkg::SHIFT_W){1'b0}}, max_shift_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign cfg.base_delay = base_delay_r;
  assign cfg.max_shift  = max_shift_r;

endmodule
`default_nettype wire

// ----- src/flbt_table.sv -----
`default_nettype none
module flbt_table #(
  parameter int TABLE_ENTRIES = flbt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd_en,
  input  wire flbt_pkg::item_t  item,
  input  wire flbt_pkg::cfg_t   cfg,
  output flbt_pkg::result_t     res
);

  logic [TABLE_ENTRIES-1:0]         valid_r;
  logic [flbt_pkg::ADDR_W-1:0]      addr_r [TABLE_ENTRIES];
  logic [flbt_pkg::COUNT_W-1:0]     cnt_r  [TABLE_ENTRIES];
  logic [flbt_pkg::TIME_W-1:0]      time_r [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0]         hit;
  logic [TABLE_ENTRIES-1:0]         free_sel;
  logic                             hit_any;
  logic                             free_any;
  logic [flbt_pkg::COUNT_W-1:0]     hit_cnt;
  logic [flbt_pkg::TIME_W-1:0]      hit_time;
  logic [flbt_pkg::COUNT_W-1:0]     sh;
  logic [flbt_pkg::TIME_W-1:0]      elapsed;
  logic [flbt_pkg::WIN_W-1:0]       window;
  logic                             is_fail;
  logic                             is_succ;

  assign is_fail = (item.cmd == flbt_pkg::CMD_FAIL);
  assign is_succ = (item.cmd == flbt_pkg::CMD_SUCCESS);

  // associative match, addresses are unique so hit is at most one-hot
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = valid_r[i] && (addr_r[i] == item.ip_addr);
    end
  end

  // lowest free slot
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      free_sel[i] = !valid_r[i] && !seen;
      seen        = seen | !valid_r[i];
    end
  end

  assign hit_any  = |hit;
  assign free_any = |free_sel;

  always_comb begin
    hit_cnt  = '0;
    hit_time = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_cnt  = hit_cnt  | (cnt_r[i]  & {flbt_pkg::COUNT_W{hit[i]}});
      hit_time = hit_time | (time_r[i] & {flbt_pkg::TIME_W{hit[i]}});
    end
  end

  assign sh      = (hit_cnt > cfg.max_shift) ? cfg.max_shift : hit_cnt;
  assign elapsed = item.now_time - hit_time;
  assign window  = {{(flbt_pkg::WIN_W-flbt_pkg::DELAY_W){1'b0}}, cfg.base_delay} << sh;

  always_comb begin
    res.banned        = (item.cmd == flbt_pkg::CMD_CHECK) && hit_any &&
                        ({{(flbt_pkg::WIN_W-flbt_pkg::TIME_W){1'b0}}, elapsed} < window);
    res.entry_dropped = is_fail && !hit_any && !free_any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd_en) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (is_fail && !hit_any && free_sel[i]) begin
          valid_r[i] <= 1'b1;
        end else if (is_succ && hit[i]) begin
          valid_r[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && is_fail) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit[i]) begin
          if (cnt_r[i] != flbt_pkg::COUNT_MAX) begin
            cnt_r[i] <= cnt_r[i] + {{(flbt_pkg::COUNT_W-1){1'b0}}, 1'b1};
          end
          time_r[i] <= item.now_time;
        end else if (!hit_any && free_sel[i]) begin
          addr_r[i] <= item.ip_addr;
          cnt_r[i]  <= '0;
          time_r[i] <= item.now_time;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/failed_login_backoff_table.sv -----
// an accepted input word is registered in item_r, and its result word in res_r
// throughput: one word per cycle while out_tready is not held low, the table lookup and update finish in one pass
// a lookup sees every update of the word before it, written at the same edge as its result
// reset: synchronous, active low; clears all table valid bits at once (no sweep)
// and loads base_delay 500 and max_shift 13
`default_nettype none
module failed_login_backoff_table #(
  parameter int TABLE_ENTRIES = flbt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // ip_addr [31:0], now_time [63:32]
  input  wire logic [1:0]  in_tuser,   // cmd [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // banned [0], entry_dropped [1], zero [7:2]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  flbt_pkg::cfg_t    cfg;
  flbt_pkg::item_t   item_r;
  flbt_pkg::result_t res;
  flbt_pkg::result_t res_r;
  logic              item_vld_r;
  logic              out_vld_r;
  logic              advance;

  flbt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // word moves to the result register when that register is free or being drained
  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  flbt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .item   (item_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd      <= in_tuser;
      item_r.ip_addr  <= in_tdata[31:0];
      item_r.now_time <= in_tdata[63:32];
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res_r.entry_dropped, res_r.banned};

endmodule
`default_nettype wire
